// ===== design/periodic_timer_bank_core_assert.svh =====
// assertion macros used by the timer bank core rtl
`ifndef PERIODIC_TIMER_BANK_CORE_ASSERT_SVH
`define PERIODIC_TIMER_BANK_CORE_ASSERT_SVH

// same-cycle implication
`define PTB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("timer bank assertion failed");

// next-cycle implication
`define PTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("timer bank assertion failed");

`endif

// ===== design/ptb_pkg.sv =====
`default_nettype none

package ptb_pkg;

	localparam int ID_W            = 8;
	localparam int TICK_W          = 32;
	localparam int NUM_TIMERS_DEF  = 8;
	localparam int MAX_TIMERS      = 256;

	typedef enum logic [1:0] {
		OP_CHECK = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_SET   = 2'd3
	} op_t;

endpackage

`default_nettype wire

// ===== design/ptb_ram.sv =====
`default_nettype none

// simple dual-port ram, one write and one registered read
module ptb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [AW-1:0]        waddr,
	input  wire logic [WIDTH-1:0]     wdata,
	input  wire logic [AW-1:0]        raddr,
	output logic      [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== design/periodic_timer_bank_core.sv =====
`default_nettype none

// channel   | handshake              | fields
// ----------+------------------------+------------------------------------------
// request   | start && !busy         | operation, timer_id, now_tick, interval
// result    | done (one-cycle pulse) | fired, fired_id
//
// one request per cycle unless busy; results pass stage 1 then the result register
// deadlines and periods sit in two rams with a registered read;
// the read is issued with the request and modified/written back in the cycle after;
// a write and a read of the same entry on the same edge are bridged by forwarding
// busy is high during reset and until ready_q is set after reset is released
// the receiver cannot stall, so results are never held back

module periodic_timer_bank_core #(
	parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [1:0]                  operation,
	input  wire logic [ptb_pkg::ID_W-1:0]    timer_id,
	input  wire logic [ptb_pkg::TICK_W-1:0]  now_tick,
	input  wire logic [ptb_pkg::TICK_W-1:0]  interval,
	output logic                             done,
	output logic                             fired,
	output logic      [ptb_pkg::ID_W-1:0]    fired_id
);

`include "periodic_timer_bank_core_assert.svh"

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int TW    = ptb_pkg::TICK_W;
	localparam int IW    = ptb_pkg::ID_W;

	// reset recovery: hold off requests until ready_q is set
	logic ready_q;
	logic accept;

	// stage 1: request registered alongside the ram read
	logic                 v_s1;
	ptb_pkg::op_t         op_s1;
	logic [IW-1:0]        id_s1;
	logic [TW-1:0]        now_s1;
	logic [TW-1:0]        ival_s1;
	logic                 in_bank_s1;
	logic                 fwd_dl_s1;
	logic [TW-1:0]        fwd_dl_data_s1;
	logic                 fwd_p_s1;
	logic [TW-1:0]        fwd_p_data_s1;

	// per-timer flags in flops, reset clears them at once
	logic [NUM_TIMERS-1:0] running_q;
	logic [NUM_TIMERS-1:0] armed_q;
	logic [NUM_TIMERS-1:0] pvalid_q;

	logic [IDX_W-1:0] rd_idx;
	logic [IDX_W-1:0] idx_s1;
	logic [TW-1:0]    dl_ram;
	logic [TW-1:0]    p_ram;

	logic             running_rd;
	logic             armed_rd;
	logic [TW-1:0]    dl_rd;
	logic [TW-1:0]    p_rd;
	logic [TW-1:0]    diff;
	logic             reached;
	logic [TW-1:0]    dl_next;
	logic             dl_we;
	logic             p_we;
	logic             hit;
	logic             is_check;

	assign busy   = !ready_q;
	assign accept = start && !busy;
	assign rd_idx = timer_id[IDX_W-1:0];
	assign idx_s1 = id_s1[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
		end else begin
			ready_q <= 1'b1;
		end
	end

	// deadline store, undefined until first arm
	ptb_ram #(.WIDTH(TW), .DEPTH(NUM_TIMERS)) u_dl_ram (
		.clk   (clk),
		.we    (dl_we),
		.waddr (idx_s1),
		.wdata (dl_next),
		.raddr (rd_idx),
		.rdata (dl_ram)
	);

	// period store, reads as zero until its valid bit is set
	ptb_ram #(.WIDTH(TW), .DEPTH(NUM_TIMERS)) u_p_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (idx_s1),
		.wdata (ival_s1),
		.raddr (rd_idx),
		.rdata (p_ram)
	);

	// flags are current by the time stage 1 reads them
	always_comb begin
		running_rd = running_q[idx_s1];
		armed_rd   = armed_q[idx_s1];
		dl_rd      = fwd_dl_s1 ? fwd_dl_data_s1 : dl_ram;
		if (fwd_p_s1) begin
			p_rd = fwd_p_data_s1;
		end else if (pvalid_q[idx_s1]) begin
			p_rd = p_ram;
		end else begin
			p_rd = '0;
		end
	end

	// wrapped compare: reached when now - deadline is in the lower half range
	assign diff     = now_s1 - dl_rd;
	assign reached  = !diff[TW-1];
	assign dl_next  = now_s1 + p_rd;
	assign is_check = v_s1 && in_bank_s1 && (op_s1 == ptb_pkg::OP_CHECK);

	always_comb begin
		dl_we = 1'b0;
		hit   = 1'b0;
		if (is_check && running_rd) begin
			if (!armed_rd) begin
				dl_we = 1'b1;
			end else if (reached) begin
				dl_we = 1'b1;
				hit   = 1'b1;
			end
		end
	end

	assign p_we = v_s1 && in_bank_s1 && (op_s1 == ptb_pkg::OP_SET);

	// flag updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
			armed_q   <= '0;
			pvalid_q  <= '0;
		end else if (v_s1 && in_bank_s1) begin
			unique case (op_s1)
				ptb_pkg::OP_CHECK: begin
					armed_q[idx_s1] <= running_rd;
				end
				ptb_pkg::OP_START: begin
					running_q[idx_s1] <= 1'b1;
				end
				ptb_pkg::OP_STOP: begin
					running_q[idx_s1] <= 1'b0;
				end
				ptb_pkg::OP_SET: begin
					pvalid_q[idx_s1] <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	// request payload and forwarding from a write landing on the read edge
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1          <= ptb_pkg::op_t'(operation);
			id_s1          <= timer_id;
			now_s1         <= now_tick;
			ival_s1        <= interval;
			in_bank_s1     <= ({1'b0, timer_id} < (IW + 1)'(NUM_TIMERS));
			fwd_dl_s1      <= dl_we && (id_s1 == timer_id);
			fwd_dl_data_s1 <= dl_next;
			fwd_p_s1       <= p_we && (id_s1 == timer_id);
			fwd_p_data_s1  <= ival_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done  <= 1'b0;
			fired <= 1'b0;
		end else begin
			done  <= v_s1;
			fired <= hit;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			fired_id <= id_s1;
		end
	end

	// every request in stage 1 yields exactly one result next cycle
	`PTB_ASSERT_NEXT(a_result_follows, clk, arst_n, v_s1, done)
	// no result without a request behind it
	`PTB_ASSERT_NEXT(a_no_spurious, clk, arst_n, !v_s1, !done)
	// a fire is only ever flagged on a result
	`PTB_ASSERT_SAME(a_fire_marked, clk, arst_n, fired, done)
	// a fire needs a running, already armed timer
	`PTB_ASSERT_SAME(a_fire_armed, clk, arst_n, hit, (running_rd && armed_rd && is_check))

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

typedef struct packed {
	logic                     fired;
	logic [ptb_pkg::ID_W-1:0] id;
} fire_result_t;

// keeps its own copy of the timer bank and the queue of fire results still due
class timer_scoreboard;
	localparam int BANK = ptb_pkg::NUM_TIMERS_DEF;
	localparam bit [ptb_pkg::TICK_W-1:0] HALF_RANGE = 32'h8000_0000;

	bit                      running  [BANK];
	bit                      armed    [BANK];
	bit [ptb_pkg::TICK_W-1:0] deadline [BANK];
	bit [ptb_pkg::TICK_W-1:0] period   [BANK];
	fire_result_t            pending_fires [$];
	int                      error_count;

	function new();
		error_count = 0;
		foreach (running[i]) begin
			running[i]  = 1'b0;
			armed[i]    = 1'b0;
			deadline[i] = '0;
			period[i]   = '0;
		end
	endfunction

	function fire_result_t apply_timer_op(ptb_pkg::op_t op, bit [ptb_pkg::ID_W-1:0] id,
			bit [ptb_pkg::TICK_W-1:0] now, bit [ptb_pkg::TICK_W-1:0] ival);
		fire_result_t res;
		res.fired = 1'b0;
		res.id    = id;
		if (id < BANK) begin
			case (op)
				ptb_pkg::OP_CHECK: begin
					if (!running[id]) begin
						armed[id] = 1'b0;
					end else if (!armed[id]) begin
						deadline[id] = now + period[id];
						armed[id]    = 1'b1;
					end else if (bit'((now - deadline[id]) < HALF_RANGE)) begin
						deadline[id] = now + period[id];
						res.fired    = 1'b1;
					end
				end
				ptb_pkg::OP_START: running[id] = 1'b1;
				ptb_pkg::OP_STOP:  running[id] = 1'b0;
				default:           period[id]  = ival;
			endcase
		end
		return res;
	endfunction

	function void note_request(ptb_pkg::op_t op, bit [ptb_pkg::ID_W-1:0] id,
			bit [ptb_pkg::TICK_W-1:0] now, bit [ptb_pkg::TICK_W-1:0] ival);
		pending_fires.push_back(apply_timer_op(op, id, now, ival));
	endfunction

	function void check_result(logic fired, logic [ptb_pkg::ID_W-1:0] id);
		fire_result_t want;
		if (pending_fires.size() == 0) begin
			$error("result with no request outstanding: fired %0d, fired_id %0d", fired, id);
			error_count++;
			return;
		end
		want = pending_fires.pop_front();
		if (fired !== want.fired) begin
			$error("fired: expected %0d, actual %0d", want.fired, fired);
			error_count++;
		end
		if (id !== want.id) begin
			$error("fired_id: expected %0d, actual %0d", want.id, id);
			error_count++;
		end
	endfunction

	function int pending();
		return pending_fires.size();
	endfunction
endclass

module testbench;

	localparam int NUM_TIMERS  = ptb_pkg::NUM_TIMERS_DEF;
	localparam int QUIET_LIMIT = 2000;    // cycles with no request and no result
	localparam int RANDOM_REQS = 550;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	logic [1:0]                   operation = ptb_pkg::OP_CHECK;
	logic [ptb_pkg::ID_W-1:0]     timer_id = '0;
	logic [ptb_pkg::TICK_W-1:0]   now_tick = '0;
	logic [ptb_pkg::TICK_W-1:0]   interval = '0;
	logic                         busy;
	logic                         done;
	logic                         fired;
	logic [ptb_pkg::ID_W-1:0]     fired_id;

	int                           quiet_cycles = 0;
	bit [ptb_pkg::TICK_W-1:0]     sys_tick;
	timer_scoreboard              sb;

	periodic_timer_bank_core #(
		.NUM_TIMERS(NUM_TIMERS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.timer_id(timer_id),
		.now_tick(now_tick),
		.interval(interval),
		.done(done),
		.fired(fired),
		.fired_id(fired_id)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// monitor: everything is sampled at the rising edge, before the block's own updates land
	always @(posedge clk) begin
		logic taken;
		taken = arst_n && start && (busy === 1'b0);
		if (taken)
			sb.note_request(ptb_pkg::op_t'(operation), timer_id, now_tick, interval);
		if (arst_n && done !== 1'b0)
			sb.check_result(fired, fired_id);
		if (taken || (arst_n && done !== 1'b0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	// watchdog: a stuck handshake or a lost result ends the run here
	initial begin
		do @(negedge clk); while (quiet_cycles < QUIET_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// present one request and hold it until the block takes it
	// start stays high on return, so a back-to-back request needs no toggle on it
	task automatic send(ptb_pkg::op_t op, int id, bit [ptb_pkg::TICK_W-1:0] now,
			bit [ptb_pkg::TICK_W-1:0] ival);
		start     <= 1'b1;
		operation <= op;
		timer_id  <= id[ptb_pkg::ID_W-1:0];
		now_tick  <= now;
		interval  <= ival;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// sender gap, with junk on the payload while start is low
	task automatic idle(int cycles);
		repeat (cycles) begin
			start     <= 1'b0;
			operation <= 2'($urandom_range(0, 3));
			timer_id  <= ptb_pkg::ID_W'($urandom_range(0, 255));
			now_tick  <= $urandom;
			interval  <= $urandom;
			@(posedge clk);
		end
	endtask

	// hold off until every request in flight has produced its result
	// the wait polls on the falling edge so it never races the monitor
	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
		@(posedge clk);
	endtask

	initial begin
		ptb_pkg::op_t op;
		int  id;
		int  pick;
		bit  noise;
		bit [ptb_pkg::TICK_W-1:0] now;
		bit [ptb_pkg::TICK_W-1:0] ival;

		sb = new();
		sys_tick = $urandom;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// ---- directed part ----
		// ordinary period: arm, just short of the deadline, on it, then the half-range edge
		send(ptb_pkg::OP_SET,   0, 32'd0, 32'd100);
		send(ptb_pkg::OP_START, 0, 32'd0, 32'd0);
		send(ptb_pkg::OP_CHECK, 0, 32'd1000, 32'd0);           // arms, deadline 1100
		send(ptb_pkg::OP_CHECK, 0, 32'd1099, 32'd0);           // one tick early
		send(ptb_pkg::OP_CHECK, 0, 32'd1100, 32'd0);           // fires, deadline 1200
		// latest tick still counted as reached
		send(ptb_pkg::OP_CHECK, 0, 32'd1200 + 32'h7FFF_FFFF, 32'd0);
		// exactly half a range past the new deadline: no fire
		send(ptb_pkg::OP_CHECK, 0, 32'd1300 + 32'hFFFF_FFFF, 32'h0);
		// new interval while armed keeps the old deadline
		send(ptb_pkg::OP_SET,   0, 32'hFFFF_FFFF, 32'd5);
		// stop then start with no check between: old deadline still live
		send(ptb_pkg::OP_STOP,  0, 32'd0, 32'd0);
		send(ptb_pkg::OP_START, 0, 32'd0, 32'd0);
		send(ptb_pkg::OP_CHECK, 0, 32'h8000_0000, 32'd0);
		// zero period, with the tick at its top and the deadline at the half-range distance
		send(ptb_pkg::OP_START, 1, 32'd0, 32'hFFFF_FFFF);
		send(ptb_pkg::OP_CHECK, 1, 32'hFFFF_FFFF, 32'd0);      // arms at deadline = now
		send(ptb_pkg::OP_CHECK, 1, 32'hFFFF_FFFF, 32'd0);      // fires at once
		send(ptb_pkg::OP_CHECK, 1, 32'h7FFF_FFFF, 32'd0);      // exactly half a range back: no fire
		// check on a stopped timer disarms it
		send(ptb_pkg::OP_STOP,  1, 32'd0, 32'd0);
		send(ptb_pkg::OP_CHECK, 1, 32'd0, 32'd0);
		send(ptb_pkg::OP_START, 1, 32'd0, 32'd0);
		send(ptb_pkg::OP_CHECK, 1, 32'd12, 32'd0);             // re-arms rather than firing
		// widest period on the top timer, deadline wraps past zero
		send(ptb_pkg::OP_SET,   NUM_TIMERS - 1, 32'd0, 32'hFFFF_FFFF);
		send(ptb_pkg::OP_START, NUM_TIMERS - 1, 32'd0, 32'd0);
		send(ptb_pkg::OP_CHECK, NUM_TIMERS - 1, 32'd7, 32'd0);
		// ids past the bank are ignored whatever the operation
		send(ptb_pkg::OP_START, NUM_TIMERS, 32'd0, 32'd0);
		send(ptb_pkg::OP_SET,   255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(ptb_pkg::OP_CHECK, 255, 32'hFFFF_FFFF, 32'd0);
		drain();

		// ---- random part ----
		// mostly in-bank traffic on a rising tick, so timers arm and fire often; the rest is noise
		for (int n = 0; n < RANDOM_REQS; n++) begin
			noise = ($urandom_range(0, 99) < 20);
			if (noise) begin
				op   = ptb_pkg::op_t'($urandom_range(0, 3));
				id   = $urandom_range(0, 255);
				now  = $urandom;
				ival = $urandom;
			end else begin
				id   = $urandom_range(0, NUM_TIMERS - 1);
				pick = $urandom_range(0, 99);
				if (pick < 60)
					op = ptb_pkg::OP_CHECK;
				else if (pick < 72)
					op = ptb_pkg::OP_START;
				else if (pick < 80)
					op = ptb_pkg::OP_STOP;
				else
					op = ptb_pkg::OP_SET;
				sys_tick += $urandom_range(0, 24);
				if ($urandom_range(0, 49) == 0)
					sys_tick += $urandom;       // occasional large jump, either side of half range
				now  = sys_tick;
				ival = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 80);
			end
			send(op, id, now, ival);
			if (n == RANDOM_REQS / 2)
				drain();
			else if ((n < 200 || n >= 350) && $urandom_range(0, 99) < 16)
				idle(1);
		end

		drain();
		repeat (8) @(posedge clk);   // catch any stray result after the last one due

		if (sb.error_count == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
